[sv/mhpq_pkg.sv]
`default_nettype none
package mhpq_pkg;
   localparam int DEPTH_DEFAULT = 16;
   localparam int KEY_WIDTH     = 32;
   localparam int OCC_WIDTH     = 5;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_POP    = 1'b1
   } func_type;
endpackage
`default_nettype wire

[sv/mhpq_cell.sv]
`default_nettype none
// One slot of a sorted systolic row. Slot 0 holds the minimum.
// Insert: the new key flows right; each slot keeps the smaller and passes the larger.
// Pop: each slot takes its right neighbor's key.
module mhpq_cell
   import mhpq_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        ins_valid,
   input  wire logic signed [KEY_WIDTH-1:0] ins_key,
   input  wire logic                        shift_left,
   input  wire logic                        right_full,
   input  wire logic signed [KEY_WIDTH-1:0] right_key,
   output logic                             pass_valid,
   output logic signed [KEY_WIDTH-1:0]      pass_key,
   output logic                             full,
   output logic signed [KEY_WIDTH-1:0]      key
);
   logic                        full_ff, full_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic                        pass_valid_ff, pass_valid_in;
   logic signed [KEY_WIDTH-1:0] pass_key_ff, pass_key_in;

   // keep the smaller key, hand the larger to the right
   always_comb begin
      full_in       = full_ff;
      key_in        = key_ff;
      pass_valid_in = 1'b0;
      pass_key_in   = pass_key_ff;
      if (shift_left) begin
         full_in = right_full;
         key_in  = right_key;
      end else if (ins_valid) begin
         if (!full_ff) begin
            full_in = 1'b1;
            key_in  = ins_key;
         end else if (ins_key < key_ff) begin
            key_in        = ins_key;
            pass_valid_in = 1'b1;
            pass_key_in   = key_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_key_in   = ins_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         full_ff       <= full_in;
         pass_valid_ff <= pass_valid_in;
      end
      key_ff      <= key_in;
      pass_key_ff <= pass_key_in;
   end

   assign pass_valid = pass_valid_ff;
   assign pass_key   = pass_key_ff;
   assign full       = full_ff;
   assign key        = key_ff;
endmodule
`default_nettype wire

[sv/min_heap_priority_queue.sv]
// Min-priority queue built as a sorted row of DEPTH cells.
// An insert is answered once its key has rippled down the row, one cell a cycle;
// a pop or a rejected item is answered without that wait. One item at a time:
// a new request is accepted only after the last result has been taken.
// Reset: synchronous, active high; empties the queue and drops any pending result.
`default_nettype none
module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic signed [KEY_WIDTH-1:0]  req_item_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [KEY_WIDTH-1:0]       rsp_popped_value,
   output logic [1:0]                        rsp_status,
   output logic [OCC_WIDTH-1:0]              rsp_occupancy
);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          wait_ff, wait_in;
   logic signed [KEY_WIDTH-1:0] pop_ff, pop_in;
   logic [1:0]             stat_ff, stat_in;

   logic                        ins_go, pop_go;
   logic [DEPTH:0]              cv;
   logic signed [KEY_WIDTH-1:0] ck [DEPTH+1];
   logic [DEPTH:0]              fl;
   logic signed [KEY_WIDTH-1:0] kk [DEPTH+1];

   assign req_ready = (state_ff == ST_IDLE);
   wire accept = req_valid && req_ready;
   assign ins_go = accept && (req_func == FUNC_INSERT) && (count_ff < CW'(DEPTH));
   assign pop_go = accept && (req_func == FUNC_POP) && (count_ff != '0);

   assign cv[0]     = ins_go;
   assign ck[0]     = req_item_value;
   assign fl[DEPTH] = 1'b0;
   assign kk[DEPTH] = '0;

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mhpq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ins_valid (cv[i]),
         .ins_key   (ck[i]),
         .shift_left(pop_go),
         .right_full(fl[i+1]),
         .right_key (kk[i+1]),
         .pass_valid(cv[i+1]),
         .pass_key  (ck[i+1]),
         .full      (fl[i]),
         .key       (kk[i])
      );
   end

   // sequence one item: wait for the ripple, then hold the result
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      wait_in  = wait_ff;
      pop_in   = pop_ff;
      stat_in  = stat_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            pop_in  = '0;
            stat_in = STATUS_OK;
            wait_in = '0;
            if (req_func == FUNC_INSERT) begin
               if (ins_go) begin
                  count_in = count_ff + 1'b1;
                  wait_in  = CW'(DEPTH - 1);
               end else begin
                  stat_in = STATUS_FULL;
               end
            end else if (pop_go) begin
               count_in = count_ff - 1'b1;
               pop_in   = kk[0];
            end else begin
               stat_in = STATUS_EMPTY;
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (wait_ff == '0) state_in = ST_RESP;
            else wait_in = wait_ff - 1'b1;
         end
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         wait_ff  <= wait_in;
      end
      pop_ff  <= pop_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_popped_value = pop_ff;
   assign rsp_status       = stat_ff;
   assign rsp_occupancy    = OCC_WIDTH'(count_ff);

   // checks
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count over depth");
   a_head_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |-> (fl[0] == (count_ff != '0)))
      else $error("head slot disagrees with count");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule
`default_nettype wire
